// ===== rtl/iss_pkg.sv =====
`default_nettype none

package iss_pkg;

  // Storage size and field widths
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int OP_W     = 3;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  // common width for comparing an index against the count
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  // value returned on a miss
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  // request opcodes; code 7 is unused and does nothing
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_GET        = 3'd6
  } opcode_t;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    ACT_HOLD       = 2'd0,
    ACT_LOAD_NEW   = 2'd1,
    ACT_TAKE_LOWER = 2'd2,
    ACT_TAKE_UPPER = 2'd3
  } cell_act_t;

  // result of one request
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     hit;
    logic                     rejected_full;
    logic [CNT_W-1:0]         element_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/iss_if.sv =====
`default_nettype none

// Request channel
interface iss_in_if
  import iss_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

// Result channel
interface iss_out_if
  import iss_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     hit;
  logic                     rejected_full;
  logic [CNT_W-1:0]         element_count;

  modport source (output valid, output read_value, output hit, output rejected_full,
                  output element_count, input ready);
  modport sink   (input valid, input read_value, input hit, input rejected_full,
                  input element_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/iss_cell.sv =====
`default_nettype none

// One storage cell of the chain: holds a value, or takes the new value or
// the value of either neighbour.
module iss_cell
  import iss_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_act_t                act,
  input  wire logic signed [DATA_W-1:0] new_value,
  input  wire logic signed [DATA_W-1:0] lower_value,
  input  wire logic signed [DATA_W-1:0] upper_value,
  output logic signed [DATA_W-1:0]      value_q
);

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  // next value select
  always_comb begin
    case (act)
      ACT_LOAD_NEW:   value_nxt = new_value;
      ACT_TAKE_LOWER: value_nxt = lower_value;
      ACT_TAKE_UPPER: value_nxt = upper_value;
      default:        value_nxt = value_r;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_q = value_r;

endmodule

`default_nettype wire

// ===== rtl/iss_ctrl.sv =====
`default_nettype none

// Request decode: works out the target index, drives every cell's action,
// and forms the result and the next count.
module iss_ctrl
  import iss_pkg::*;
(
  input  wire logic                                 fire,
  input  wire logic [OP_W-1:0]                      opcode,
  input  wire logic [POS_W-1:0]                     position,
  input  wire logic [CNT_W-1:0]                     count,
  input  wire logic [CAPACITY-1:0][DATA_W-1:0]      cell_q,
  output cell_act_t                                 cell_act [CAPACITY],
  output logic [CNT_W-1:0]                          count_nxt,
  output rsp_t                                      rsp
);

  logic [CMP_W-1:0]         cnt_ext;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         where;
  logic                     is_ins;
  logic                     is_rem;
  logic                     is_get;
  logic                     full;
  logic                     found;
  logic                     do_ins;
  logic                     do_rem;
  logic signed [DATA_W-1:0] sel_value;

  assign cnt_ext = CMP_W'(count);
  assign pos_ext = CMP_W'(position);
  assign full    = (count == CNT_W'(CAPACITY));

  // opcode decode and target index
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    is_get = 1'b0;
    where  = '0;
    case (opcode_t'(opcode))
      OP_PUSH_FRONT: begin
        is_ins = 1'b1;
      end
      OP_PUSH_BACK: begin
        is_ins = 1'b1;
        where  = cnt_ext;
      end
      OP_INSERT: begin
        is_ins = 1'b1;
        where  = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
      end
      OP_POP_FRONT: begin
        is_rem = 1'b1;
      end
      OP_POP_BACK: begin
        is_rem = 1'b1;
        where  = (count != '0) ? (cnt_ext - CMP_W'(1)) : '0;
      end
      OP_REMOVE: begin
        is_rem = 1'b1;
        where  = pos_ext;
      end
      OP_GET: begin
        is_get = 1'b1;
        where  = pos_ext;
      end
      default: ;
    endcase
  end

  assign found     = (where < cnt_ext);
  assign sel_value = cell_q[where[IDX_W-1:0]];
  assign do_ins    = fire && is_ins && !full;
  assign do_rem    = fire && is_rem && found;

  // result and next count
  always_comb begin
    rsp.read_value    = '0;
    rsp.hit           = 1'b0;
    rsp.rejected_full = 1'b0;
    count_nxt         = count;
    if (is_ins) begin
      if (full) begin
        rsp.rejected_full = 1'b1;
      end else begin
        count_nxt = count + CNT_W'(1);
      end
    end else if (is_rem || is_get) begin
      rsp.hit        = found;
      rsp.read_value = found ? sel_value : MISS_VALUE;
      if (is_rem && found) begin
        count_nxt = count - CNT_W'(1);
      end
    end
    rsp.element_count = count_nxt;
  end

  // per-cell actions: shift up above an insert, shift down from a remove
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cell_act[k] = ACT_HOLD;
      if (do_ins) begin
        if (CMP_W'(k) > where) begin
          cell_act[k] = ACT_TAKE_LOWER;
        end else if (CMP_W'(k) == where) begin
          cell_act[k] = ACT_LOAD_NEW;
        end
      end else if (do_rem) begin
        if (CMP_W'(k) >= where) begin
          cell_act[k] = ACT_TAKE_UPPER;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/indexed_sequence_store_core.sv =====
`default_nettype none

// Indexed sequence store: an ordered list of up to CAPACITY signed values
// held in a row of cells that shift up on insert and down on remove.
//
// in_chan  : request channel (opcode, position, item_value), valid/ready.
// out_chan : result channel (read_value, hit, rejected_full, element_count).
// Every request yields exactly one result.
//
// The result is registered: a request taken in one cycle shows its result
// on out_chan in the next. One request per cycle is sustained while results
// are accepted; every cell shifts or holds in parallel, and the single
// output register sets the throughput. The result register frees up in the
// cycle it is taken, so in_chan stays ready while out_chan.ready is high;
// while a result waits unaccepted, in_chan.ready is low and the store holds.
// Reset empties the store (count zero) and clears the output valid; the
// cell contents are not cleared, as nothing at or past the count is read.
module indexed_sequence_store_core
  import iss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  iss_in_if.sink     in_chan,
  iss_out_if.source  out_chan
);

  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic                        out_valid_r;
  rsp_t                        rsp_r;
  rsp_t                        rsp_nxt;
  logic                        fire;
  cell_act_t                   cell_act [CAPACITY];
  logic [CAPACITY-1:0][DATA_W-1:0] cell_q;

  // handshake
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;

  iss_ctrl u_ctrl (
    .fire      (fire),
    .opcode    (in_chan.opcode),
    .position  (in_chan.position),
    .count     (count_r),
    .cell_q    (cell_q),
    .cell_act  (cell_act),
    .count_nxt (count_nxt),
    .rsp       (rsp_nxt)
  );

  // chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] lower_v;
    logic signed [DATA_W-1:0] upper_v;
    logic signed [DATA_W-1:0] value_q;
    if (g == 0) begin : g_first
      assign lower_v = '0;
    end else begin : g_mid_lo
      assign lower_v = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper_v = '0;
    end else begin : g_mid_hi
      assign upper_v = cell_q[g+1];
    end
    iss_cell u_cell (
      .clk         (clk),
      .act         (cell_act[g]),
      .new_value   (in_chan.item_value),
      .lower_value (lower_v),
      .upper_value (upper_v),
      .value_q     (value_q)
    );
    assign cell_q[g] = value_q;
  end

  // count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r <= count_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.read_value    = rsp_r.read_value;
  assign out_chan.hit           = rsp_r.hit;
  assign out_chan.rejected_full = rsp_r.rejected_full;
  assign out_chan.element_count = rsp_r.element_count;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && fire |=> (count_r == $past(count_r)) ||
                      (count_r == $past(count_r) + CNT_W'(1)) ||
                      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("count moved by more than one on a request");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !fire |=> $stable(count_r))
    else $error("count changed without a request");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rsp_r.rejected_full |->
      !rsp_r.hit && (rsp_r.element_count == CNT_W'(CAPACITY)))
    else $error("insert rejected while store not full");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
  import iss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // opcode with no action, absent from the package enum
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;
  localparam int RANDOM_REQUESTS = 340;
  localparam int ROWS = 25;

  // one line of the directed table; want_* only used on TYPED rows
  typedef struct {
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
    int                       reps;
    bit                       typed;
    logic signed [DATA_W-1:0] want_value;
    logic                     want_hit;
    logic                     want_rej;
    logic [CNT_W-1:0]         want_count;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  iss_in_if  in_if ();
  iss_out_if out_if ();

  indexed_sequence_store_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the list contents
  logic signed [DATA_W-1:0] mirror_cells [CAPACITY];
  int mirror_len = 0;

  rsp_t awaited_replies [$];
  int   mismatch_count = 0;
  int   replies_taken = 0;
  int   burst_left = 0;

  stim_row_t directed_rows [ROWS];

  // Apply one request to the mirror and return the reply it should give
  function automatic rsp_t list_reply(input logic [OP_W-1:0] op,
                                      input logic [POS_W-1:0] pos,
                                      input logic signed [DATA_W-1:0] val);
    rsp_t r;
    int   where;
    int   k;
    r = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (op == OP_PUSH_FRONT) where = 0;
        else if (op == OP_PUSH_BACK) where = mirror_len;
        else where = int'(pos);
        if (mirror_len >= CAPACITY) begin
          r.rejected_full = 1'b1;
        end else begin
          // past the end appends at the back
          if (where > mirror_len) where = mirror_len;
          for (k = mirror_len; k > where; k--) mirror_cells[k] = mirror_cells[k-1];
          mirror_cells[where] = val;
          mirror_len++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
        if (op == OP_POP_FRONT) where = 0;
        else if (op == OP_POP_BACK) where = (mirror_len > 0) ? mirror_len - 1 : 0;
        else where = int'(pos);
        if (where < mirror_len) begin
          r.read_value = mirror_cells[where];
          r.hit = 1'b1;
          for (k = where; k + 1 < mirror_len; k++) mirror_cells[k] = mirror_cells[k+1];
          mirror_len--;
        end else begin
          r.read_value = MISS_VALUE;
        end
      end
      OP_GET: begin
        if (int'(pos) < mirror_len) begin
          r.read_value = mirror_cells[pos];
          r.hit = 1'b1;
        end else begin
          r.read_value = MISS_VALUE;
        end
      end
      default: ;
    endcase
    r.element_count = CNT_W'(mirror_len);
    return r;
  endfunction

  // Offer one request in bursts with random gaps; log its reply once taken
  task automatic offer(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                       input logic signed [DATA_W-1:0] val, input bit typed,
                       input rsp_t typed_reply);
    rsp_t predicted;
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.position   <= pos;
    in_if.item_value <= val;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predicted = list_reply(op, pos, val);
    awaited_replies.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic check_field(input string field, input logic signed [DATA_W-1:0] want,
                             input logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: compare each taken reply with the oldest one awaited
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      replies_taken++;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply value %0d count %0d", $time,
                 out_if.read_value, out_if.element_count);
        mismatch_count++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("read_value", want.read_value, out_if.read_value);
        check_field("hit", want.hit, out_if.hit);
        check_field("rejected_full", want.rejected_full, out_if.rejected_full);
        check_field("element_count", want.element_count, out_if.element_count);
      end
    end
  end

  // Receiver stalls: changing pattern, plus one long hold-off
  initial begin
    int cyc;
    int mode;
    bit hold_done;
    int hold_left;
    cyc = 0;
    mode = 0;
    hold_done = 1'b0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && replies_taken >= 100) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (cyc % 4 != 3);
          default: out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
        cyc++;
      end
      @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    rsp_t                     typed_reply;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       real_ops;
    int                       n;
    int                       trend;
    int                       roll;

    directed_rows = '{
      // empty store: every read misses
      '{OP_GET,        8'd0,   32'sd0,        1, TYPED,   MISS_VALUE, 1'b0, 1'b0, 5'd0},
      '{OP_POP_FRONT,  8'd0,   32'sd0,        1, TYPED,   MISS_VALUE, 1'b0, 1'b0, 5'd0},
      '{OP_POP_BACK,   8'd0,   32'sd0,        1, TYPED,   MISS_VALUE, 1'b0, 1'b0, 5'd0},
      '{OP_REMOVE,     8'd255, 32'sd0,        1, TYPED,   MISS_VALUE, 1'b0, 1'b0, 5'd0},
      '{OP_UNUSED,     8'd255, -32'sd1,       1, TYPED,   32'sd0,     1'b0, 1'b0, 5'd0},
      // value extremes, insert past the end and at the front
      '{OP_PUSH_BACK,  8'd0,   32'h7FFFFFFF,  1, TYPED,   32'sd0,     1'b0, 1'b0, 5'd1},
      '{OP_PUSH_FRONT, 8'd0,   32'h80000000,  1, TYPED,   32'sd0,     1'b0, 1'b0, 5'd2},
      '{OP_INSERT,     8'd255, -32'sd1,       1, TYPED,   32'sd0,     1'b0, 1'b0, 5'd3},
      '{OP_INSERT,     8'd0,   32'sd5,        1, TYPED,   32'sd0,     1'b0, 1'b0, 5'd4},
      '{OP_INSERT,     8'd2,   32'h5555AAAA,  1, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      '{OP_GET,        8'd0,   32'sd0,        1, TYPED,   32'sd5,     1'b1, 1'b0, 5'd5},
      // stored minus one is a hit, one past the end a miss
      '{OP_GET,        8'd4,   32'sd0,        1, TYPED,   -32'sd1,    1'b1, 1'b0, 5'd5},
      '{OP_GET,        8'd5,   32'sd0,        1, TYPED,   MISS_VALUE, 1'b0, 1'b0, 5'd5},
      '{OP_REMOVE,     8'd1,   32'sd0,        1, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      '{OP_POP_BACK,   8'd0,   32'sd0,        1, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      '{OP_UNUSED,     8'd0,   32'sd0,        1, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      // fill up, then every insert is rejected
      '{OP_PUSH_BACK,  8'd0,   32'hA5A5A5A5, 13, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      '{OP_PUSH_FRONT, 8'd0,   32'sd1,        1, TYPED,   32'sd0,     1'b0, 1'b1, 5'd16},
      '{OP_INSERT,     8'd8,   32'sd2,        1, TYPED,   32'sd0,     1'b0, 1'b1, 5'd16},
      '{OP_PUSH_BACK,  8'd0,   32'sd3,        1, TYPED,   32'sd0,     1'b0, 1'b1, 5'd16},
      '{OP_GET,        8'd15,  32'sd0,        1, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      '{OP_REMOVE,     8'd15,  32'sd0,        1, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      '{OP_INSERT,     8'd7,   32'hCAFEBABE,  1, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      // drain past empty
      '{OP_POP_FRONT,  8'd0,   32'sd0,       17, PREDICT, 32'sd0,     1'b0, 1'b0, 5'd0},
      '{OP_GET,        8'd0,   32'sd0,        1, TYPED,   MISS_VALUE, 1'b0, 1'b0, 5'd0}
    };

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= '0;
    in_if.position   <= '0;
    in_if.item_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      typed_reply.read_value    = directed_rows[i].want_value;
      typed_reply.hit           = directed_rows[i].want_hit;
      typed_reply.rejected_full = directed_rows[i].want_rej;
      typed_reply.element_count = directed_rows[i].want_count;
      repeat (directed_rows[i].reps)
        offer(directed_rows[i].opcode, directed_rows[i].position,
              directed_rows[i].item_value, directed_rows[i].typed, typed_reply);
    end

    // random requests, drifting between growing, shrinking and mixed stretches
    typed_reply = '0;
    real_ops = 0;
    n = 0;
    while (real_ops < RANDOM_REQUESTS) begin
      trend = (n / 40) % 3;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) begin
        op = OP_UNUSED;
      end else begin
        case (trend)
          0: op = (roll < 70) ? OP_W'($urandom_range(OP_PUSH_FRONT, OP_INSERT))
                              : OP_W'($urandom_range(OP_POP_FRONT, OP_GET));
          1: op = (roll < 70) ? OP_W'($urandom_range(OP_POP_FRONT, OP_REMOVE))
                              : OP_W'($urandom_range(OP_PUSH_FRONT, OP_GET));
          default: op = OP_W'($urandom_range(OP_PUSH_FRONT, OP_GET));
        endcase
        real_ops++;
      end
      // mostly positions around the current length
      pos = ($urandom_range(0, 3) != 0) ? POS_W'($urandom_range(0, mirror_len + 1))
                                        : POS_W'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'sd0;
          1: val = -32'sd1;
          2: val = 32'h7FFFFFFF;
          default: val = 32'h80000000;
        endcase
      end else begin
        val = DATA_W'($urandom);
      end
      offer(op, pos, val, PREDICT, typed_reply);
      n++;
    end
    in_if.valid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #400us;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
